>>> rtl/core/agd_pkg.sv
// shared widths, register map and defaults for the adc glitch detector
package agd_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int THR_W     = 16;
	localparam int CHAN_W    = 2;
	localparam int CIU_W     = 3;
	localparam int STEP_W    = SAMPLE_W + 1;
	localparam int COUNT_W   = 32;
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;

	localparam int AGD_MAX_FRAMES    = 262144;
	localparam int AGD_MAX_CHANNELS  = 4;
	localparam int AGD_SETTLE_FRAMES = 64;

	localparam logic [THR_W-1:0] THRESHOLD_RST = THR_W'(64);
	localparam logic [CIU_W-1:0] CIU_RST       = CIU_W'(2);

	// register word index, taken from paddr[2]
	typedef enum logic {
		REG_THRESHOLD = 1'b0,
		REG_CHANNELS  = 1'b1
	} reg_idx_t;

	// per-channel history entry
	typedef struct packed {
		logic                primed;
		logic [SAMPLE_W-1:0] sample;
	} hist_t;

endpackage

>>> rtl/core/agd_chan_hist.sv
// per-channel history: last sample and primed flag of each channel
module agd_chan_hist #(
	parameter int MAX_CHANNELS = agd_pkg::AGD_MAX_CHANNELS,
	parameter int IDX_W        = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [IDX_W-1:0]            idx,
	input  logic                        wr_en,
	input  logic [agd_pkg::SAMPLE_W-1:0] wr_sample,
	output agd_pkg::hist_t              rd_entry
);
	import agd_pkg::*;

	logic [SAMPLE_W-1:0]     sample_q [MAX_CHANNELS];
	logic [MAX_CHANNELS-1:0] primed_q;

	// sample data is only looked at once the channel is primed
	always_ff @(posedge clk) begin
		if (wr_en) begin
			sample_q[idx] <= wr_sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q <= '0;
		end else if (wr_en) begin
			primed_q[idx] <= 1'b1;
		end
	end

	always_comb begin
		rd_entry.primed = primed_q[idx];
		rd_entry.sample = sample_q[idx];
	end

endmodule

>>> rtl/core/adc_glitch_detector_core.sv
// top level of the adc glitch detector: input stage, step check, counters and result register
//
// usage
// - sample channel: sample, channel and block_start move with sample_valid/sample_ready;
//   one transfer per interleaved converter sample, block_start on the first sample of a block
// - result channel: one result transfer per sample transfer, in order, carrying the glitch
//   flag, the counted flag, the signed step and the running error count and frame bounds
// - config: apb-style port, threshold at byte address 0, channels_in_use at byte address 4;
//   pready is tied high, write config only while no sample is in flight
// - path: an accepted sample is held in the input register, then its result in the result
//   register, which drives the result channel
// - throughput: one sample per cycle while not stalled; the step check and the history and
//   counter updates all sit in the single compute stage between the input and result registers
// - stall: when result_ready is low the result register holds; one more sample still enters
//   the input register, then sample_ready drops until the result is taken
// - reset: arst_n clears the pipeline, the channel history, the frame counter, the error count
//   and the glitch frame bounds (first bound back to MAX_FRAMES), and loads the register defaults
module adc_glitch_detector_core #(
	parameter int MAX_FRAMES    = agd_pkg::AGD_MAX_FRAMES,
	parameter int MAX_CHANNELS  = agd_pkg::AGD_MAX_CHANNELS,
	parameter int SETTLE_FRAMES = agd_pkg::AGD_SETTLE_FRAMES,
	parameter int FRAME_W       = $clog2(MAX_FRAMES)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// config port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [agd_pkg::PADDR_W-1:0]   paddr,
	input  logic [agd_pkg::PDATA_W-1:0]   pwdata,
	output logic [agd_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	// sample channel
	input  logic                          sample_valid,
	output logic                          sample_ready,
	input  logic [agd_pkg::SAMPLE_W-1:0]  sample,
	input  logic [agd_pkg::CHAN_W-1:0]    channel,
	input  logic                          block_start,
	// result channel
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic                          glitch,
	output logic                          counted,
	output logic signed [agd_pkg::STEP_W-1:0] step,
	output logic [agd_pkg::COUNT_W-1:0]   error_count,
	output logic [FRAME_W:0]              first_glitch_frame,
	output logic [FRAME_W-1:0]            last_glitch_frame
);
	import agd_pkg::*;

	localparam int IDX_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int CHX_W  = 4;   // holds channel numbers and channel counts up to 15
	localparam logic [FRAME_W-1:0] FRAME_LAST = FRAME_W'(MAX_FRAMES - 1);
	localparam logic [FRAME_W:0]   FRAME_NONE = (FRAME_W + 1)'(MAX_FRAMES);
	localparam logic [CHX_W-1:0]   CH_MAX     = CHX_W'(MAX_CHANNELS);

	// ---------------------------------------------------------------- config registers
	logic [THR_W-1:0] threshold_q;
	logic [CIU_W-1:0] ciu_q;
	logic             cfg_wr;
	reg_idx_t         cfg_idx;

	assign pready  = 1'b1;
	assign cfg_idx = reg_idx_t'(paddr[2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RST;
			ciu_q       <= CIU_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_THRESHOLD: threshold_q <= pwdata[THR_W-1:0];
				REG_CHANNELS:  ciu_q       <= pwdata[CIU_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_THRESHOLD: prdata = {{(PDATA_W-THR_W){1'b0}}, threshold_q};
			REG_CHANNELS:  prdata = {{(PDATA_W-CIU_W){1'b0}}, ciu_q};
			default:       prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------- pipeline control
	logic valid_s1, valid_s2;
	logic adv_s1, take_s1;

	// result register frees up when empty or being taken
	assign adv_s1       = valid_s1 && (!valid_s2 || result_ready);
	assign sample_ready = !valid_s1 || adv_s1;
	assign take_s1      = sample_valid && sample_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take_s1) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (result_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------- input register
	logic [SAMPLE_W-1:0] sample_s1;
	logic [CHAN_W-1:0]   channel_s1;
	logic                start_s1;

	always_ff @(posedge clk) begin
		if (take_s1) begin
			sample_s1  <= sample;
			channel_s1 <= channel;
			start_s1   <= block_start;
		end
	end

	// ---------------------------------------------------------------- compute stage
	logic [CHX_W-1:0]  chan_mod;
	logic [IDX_W-1:0]  chan_idx;
	logic [CHX_W-1:0]  eff_ch;
	logic              frame_wrap;
	hist_t             hist;

	// channel folded into the history depth by repeated subtraction
	always_comb begin
		chan_mod = {{(CHX_W-CHAN_W){1'b0}}, channel_s1};
		for (int k = 0; k < (1 << CHAN_W); k++) begin
			if (chan_mod >= CH_MAX) begin
				chan_mod = chan_mod - CH_MAX;
			end
		end
	end

	assign chan_idx = chan_mod[IDX_W-1:0];

	// channels in use clamped to 1..MAX_CHANNELS
	always_comb begin
		eff_ch = {1'b0, ciu_q};
		if (eff_ch == '0) begin
			eff_ch = CHX_W'(1);
		end else if (eff_ch > CH_MAX) begin
			eff_ch = CH_MAX;
		end
	end

	assign frame_wrap = (chan_mod + CHX_W'(1)) >= eff_ch;

	agd_chan_hist #(
		.MAX_CHANNELS (MAX_CHANNELS),
		.IDX_W        (IDX_W)
	) u_hist (
		.clk       (clk),
		.arst_n    (arst_n),
		.idx       (chan_idx),
		.wr_en     (adv_s1),
		.wr_sample (sample_s1),
		.rd_entry  (hist)
	);

	// step against the previous sample; first sample of a channel only primes it
	logic signed [STEP_W-1:0] step_c;
	logic [STEP_W-1:0]        mag_c;
	logic                     glitch_c;

	always_comb begin
		if (hist.primed) begin
			step_c = $signed({1'b0, sample_s1}) - $signed({1'b0, hist.sample});
		end else begin
			step_c = '0;
		end
		mag_c    = step_c[STEP_W-1] ? STEP_W'(-step_c) : STEP_W'(step_c);
		glitch_c = mag_c > {1'b0, threshold_q};
	end

	// frame tracking and counters
	logic [FRAME_W-1:0] frame_index_q;
	logic               later_block_q;
	logic               seen_data_q;
	logic [COUNT_W-1:0] total_q;
	logic [FRAME_W:0]   min_frame_q;
	logic [FRAME_W-1:0] max_frame_q;

	logic [FRAME_W-1:0] frame_c;
	logic [FRAME_W-1:0] frame_next;
	logic               later_c;
	logic               outside_c;
	logic               counted_c;
	logic [COUNT_W-1:0] total_c;
	logic [FRAME_W:0]   min_c;
	logic [FRAME_W-1:0] max_c;

	always_comb begin
		// block start restarts the frame count on this very sample
		frame_c = start_s1 ? '0 : frame_index_q;
		later_c = later_block_q || (start_s1 && seen_data_q);

		// settling window: frames 1..SETTLE_FRAMES-1, plus frame 0 of the first block
		outside_c = (32'(frame_c) >= 32'(SETTLE_FRAMES)) || (later_c && (frame_c == '0));
		counted_c = glitch_c && outside_c;

		total_c = total_q;
		min_c   = min_frame_q;
		max_c   = max_frame_q;
		if (counted_c) begin
			if (total_q != '1) begin
				total_c = total_q + COUNT_W'(1);
			end
			if ({1'b0, frame_c} < min_frame_q) begin
				min_c = {1'b0, frame_c};
			end
			if (frame_c > max_frame_q) begin
				max_c = frame_c;
			end
		end

		// last channel of the frame moves the index on, saturating at the last frame
		frame_next = frame_c;
		if (frame_wrap && (frame_c < FRAME_LAST)) begin
			frame_next = frame_c + FRAME_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_index_q <= '0;
			later_block_q <= 1'b0;
			seen_data_q   <= 1'b0;
			total_q       <= '0;
			min_frame_q   <= FRAME_NONE;
			max_frame_q   <= '0;
		end else if (adv_s1) begin
			frame_index_q <= frame_next;
			later_block_q <= later_c;
			seen_data_q   <= 1'b1;
			total_q       <= total_c;
			min_frame_q   <= min_c;
			max_frame_q   <= max_c;
		end
	end

	// ---------------------------------------------------------------- result register
	logic                     glitch_s2;
	logic                     counted_s2;
	logic signed [STEP_W-1:0] step_s2;
	logic [COUNT_W-1:0]       count_s2;
	logic [FRAME_W:0]         first_s2;
	logic [FRAME_W-1:0]       last_s2;

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			glitch_s2  <= glitch_c;
			counted_s2 <= counted_c;
			step_s2    <= step_c;
			count_s2   <= total_c;
			first_s2   <= min_c;
			last_s2    <= max_c;
		end
	end

	assign result_valid       = valid_s2;
	assign glitch             = glitch_s2;
	assign counted            = counted_s2;
	assign step               = step_s2;
	assign error_count        = count_s2;
	assign first_glitch_frame = first_s2;
	assign last_glitch_frame  = last_s2;

endmodule
